// File: design/despeckle_neighbor_clamp_core_macros.svh
// Assertion macros shared by the despeckle clamp checker.
// No dependencies; included by the checker file only.
`ifndef DESPECKLE_NEIGHBOR_CLAMP_CORE_MACROS_SVH
`define DESPECKLE_NEIGHBOR_CLAMP_CORE_MACROS_SVH

// Check a property at every rising edge, quiet while reset is high.
`define DNC_ASSERT(lbl, clk_i, rst_i, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) prop) \
    else $error("despeckle clamp check failed");

// Check a property at every rising edge, reset included.
`define DNC_ASSERT_ALWAYS(lbl, clk_i, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("despeckle clamp check failed");

`endif

// File: design/dnc_pkg.sv
// Shared types and constants for the despeckle neighbour clamp block.
// No dependencies; used by dnc_window, the top level and the checker.
package dnc_pkg;

  localparam int CHAN_W   = 8;     // bits per channel
  localparam int NUM_CHAN = 4;     // channel fields on the ports
  localparam int COL_W    = 12;    // position counter width
  localparam int CFG_W    = 13;    // width of a dimension register
  localparam int COL_SPAN = 4096;  // columns reachable by the counter
  localparam int DIM_MIN  = 3;     // smallest width or height
  localparam int ROW_MAX  = 4096;  // largest height

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Register index, taken from paddr[2].
  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic              frame_start;
    logic [CHAN_W-1:0] in_chan0;
    logic [CHAN_W-1:0] in_chan1;
    logic [CHAN_W-1:0] in_chan2;
    logic [CHAN_W-1:0] in_chan3;
  } dnc_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_chan0;
    logic [CHAN_W-1:0] out_chan1;
    logic [CHAN_W-1:0] out_chan2;
    logic [CHAN_W-1:0] out_chan3;
    logic [COL_W-1:0]  out_col;
    logic [COL_W-1:0]  out_row;
    logic              frame_done;
  } dnc_out_t;

endpackage

// File: design/dnc_linebuf.sv
// Two-row line store: one memory holding rows y-2 and y-1 per column.
// Depends on nothing; instantiated by despeckle_neighbor_clamp_core.
module dnc_linebuf #(
  parameter int DEPTH = 4096,
  parameter int DW    = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  output logic [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] mem_q;
  logic [DW-1:0] fwd_q;
  logic          hit_q;

  // Registered read; a same-address write in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      fwd_q <= wr_data;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q <= 1'b0;
    end else if (rd_en) begin
      hit_q <= wr_en && (rd_addr == wr_addr);
    end
  end

  assign rd_data = hit_q ? fwd_q : mem_q;

endmodule

// File: design/dnc_window.sv
// 3x3 window registers and the per-channel neighbour min/max clamp.
// Depends on dnc_pkg; instantiated by despeckle_neighbor_clamp_core.
module dnc_window #(
  parameter int CHANNELS = 3
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    shift,
  input  logic [CHANNELS-1:0][dnc_pkg::CHAN_W-1:0] top,
  input  logic [CHANNELS-1:0][dnc_pkg::CHAN_W-1:0] mid,
  input  logic [CHANNELS-1:0][dnc_pkg::CHAN_W-1:0] cur,
  output logic [CHANNELS-1:0][dnc_pkg::CHAN_W-1:0] clamped
);

  // win[0..2]: column x-2 (top, mid, bottom); win[3..5]: column x-1.
  logic [5:0][CHANNELS-1:0][dnc_pkg::CHAN_W-1:0] win;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (shift) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= cur;
    end
  end

  always_comb begin
    logic [7:0][dnc_pkg::CHAN_W-1:0] nb;
    logic [dnc_pkg::CHAN_W-1:0]      lo;
    logic [dnc_pkg::CHAN_W-1:0]      hi;
    logic [dnc_pkg::CHAN_W-1:0]      ctr;
    for (int k = 0; k < CHANNELS; k++) begin
      nb[0] = win[0][k];
      nb[1] = win[1][k];
      nb[2] = win[2][k];
      nb[3] = win[3][k];
      nb[4] = win[5][k];
      nb[5] = top[k];
      nb[6] = mid[k];
      nb[7] = cur[k];
      lo = nb[0];
      hi = nb[0];
      for (int i = 1; i < 8; i++) begin
        if (nb[i] < lo) lo = nb[i];
        if (nb[i] > hi) hi = nb[i];
      end
      ctr = win[4][k];
      if (ctr < lo) ctr = lo;
      if (ctr > hi) ctr = hi;
      clamped[k] = ctr;
    end
  end

endmodule

// File: design/despeckle_neighbor_clamp_core.sv
// Top level of the despeckle neighbour clamp: counters, stages, registers.
// Depends on dnc_pkg, dnc_linebuf and dnc_window.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------
//   in      | in        | in_valid / in_stall  | dnc_pkg::dnc_in_t
//   out     | out       | out_valid / out_stall| dnc_pkg::dnc_out_t
//   config  | in/out    | APB psel/penable     | line_width, frame_height
//
// One pixel request is accepted per clock while in_stall is low; each request passes
// through the middle stage and the registered line-store read into the result register.
// Border pixels pass through without giving a result.
// Reset is synchronous; the line store is not cleared and needs no sweep.
// A stalled result holds the result register and the middle stage; while the middle
// stage is full, in_stall rises in the same cycle.
module despeckle_neighbor_clamp_core #(
  parameter int MAX_WIDTH = 4096,
  parameter int CHANNELS  = 3
) (
  input  logic              clk,
  input  logic              rst,
  // pixel requests
  input  logic              in_valid,
  output logic              in_stall,
  input  dnc_pkg::dnc_in_t  in_data,
  // results
  output logic              out_valid,
  input  logic              out_stall,
  output dnc_pkg::dnc_out_t out_data,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Columns actually addressable: the counter cannot pass 4095.
  localparam int DEPTH = (MAX_WIDTH < dnc_pkg::COL_SPAN) ? MAX_WIDTH : dnc_pkg::COL_SPAN;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = CHANNELS * dnc_pkg::CHAN_W;
  // Upper bound of the saturated width, limited to what 13 bits hold.
  localparam int W_HI  = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;

  localparam logic [dnc_pkg::COL_W-1:0] X_LAST  = dnc_pkg::COL_W'(DEPTH - 1);
  localparam logic [dnc_pkg::CFG_W-1:0] W_MAX   = dnc_pkg::CFG_W'(W_HI);
  localparam logic [dnc_pkg::CFG_W-1:0] H_MAX   = dnc_pkg::CFG_W'(dnc_pkg::ROW_MAX);
  localparam logic [dnc_pkg::CFG_W-1:0] DIM_LOW = dnc_pkg::CFG_W'(dnc_pkg::DIM_MIN);
  localparam logic [dnc_pkg::COL_W-1:0] COL_ONE = dnc_pkg::COL_W'(1);
  localparam logic [dnc_pkg::CFG_W-1:0] CFG_ONE = dnc_pkg::CFG_W'(1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [dnc_pkg::CFG_W-1:0] line_width;
  logic [dnc_pkg::CFG_W-1:0] frame_height;

  // Byte lanes paddr[1:0] are ignored; paddr[2] picks the register.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= dnc_pkg::LINE_WIDTH_RST;
      frame_height <= dnc_pkg::FRAME_HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        dnc_pkg::REG_LINE_WIDTH:   line_width   <= pwdata[dnc_pkg::CFG_W-1:0];
        dnc_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[dnc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dnc_pkg::REG_LINE_WIDTH:   prdata = 32'(line_width);
      dnc_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default:                   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Saturate the dimensions into their legal ranges.
  logic [dnc_pkg::CFG_W-1:0] w_sat, h_sat, w_last, h_last;

  always_comb begin
    if (line_width < DIM_LOW)     w_sat = DIM_LOW;
    else if (line_width > W_MAX)  w_sat = W_MAX;
    else                          w_sat = line_width;
    if (frame_height < DIM_LOW)   h_sat = DIM_LOW;
    else if (frame_height > H_MAX) h_sat = H_MAX;
    else                          h_sat = frame_height;
    w_last = w_sat - CFG_ONE;
    h_last = h_sat - CFG_ONE;
  end

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  logic s1_valid;
  logic s1_adv;
  logic in_acc;

  // The middle stage moves on unless the result register is held.
  assign s1_adv   = s1_valid && !(out_valid && out_stall);
  assign in_stall = rst || (s1_valid && out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Position counters (input side)
  // ---------------------------------------------------------------------
  logic [dnc_pkg::COL_W-1:0] col_count, row_count;
  logic [dnc_pkg::COL_W-1:0] x, y, x_raw;
  logic                      last_col, last_row;

  always_comb begin
    x_raw    = in_data.frame_start ? '0 : col_count;
    y        = in_data.frame_start ? '0 : row_count;
    x        = (x_raw > X_LAST) ? X_LAST : x_raw;
    last_col = {1'b0, x} >= w_last;
    last_row = {1'b0, y} >= h_last;
  end

  // Advance the column; wrap the row and frame at their last position.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : y + COL_ONE;
      end else begin
        col_count <= x + COL_ONE;
        row_count <= y;
      end
    end
  end

  // Gather the configured channels of the incoming pixel.
  logic [dnc_pkg::NUM_CHAN-1:0][dnc_pkg::CHAN_W-1:0] in_all;
  logic [CHANNELS-1:0][dnc_pkg::CHAN_W-1:0]          in_pix;

  assign in_all = {in_data.in_chan3, in_data.in_chan2, in_data.in_chan1, in_data.in_chan0};
  assign in_pix = in_all[CHANNELS-1:0];

  // ---------------------------------------------------------------------
  // Middle stage: pixel, address and result flags
  // ---------------------------------------------------------------------
  logic [CHANNELS-1:0][dnc_pkg::CHAN_W-1:0] s1_cur;
  logic [AW-1:0]                            s1_addr;
  logic [dnc_pkg::COL_W-1:0]                s1_col, s1_row;
  logic                                     s1_emit, s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Centre lies one column and one row back from the arriving pixel.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cur  <= in_pix;
      s1_addr <= x[AW-1:0];
      s1_col  <= x - COL_ONE;
      s1_row  <= y - COL_ONE;
      s1_emit <= (x >= 12'd2) && (y >= 12'd2);
      s1_last <= last_col && last_row;
    end
  end

  // ---------------------------------------------------------------------
  // Line store: entry holds {row y-2, row y-1}; write back {row y-1, cur}
  // ---------------------------------------------------------------------
  logic [2*PW-1:0]                          lb_rd;
  logic [CHANNELS-1:0][dnc_pkg::CHAN_W-1:0] lb_top, lb_mid;

  dnc_linebuf #(
    .DEPTH (DEPTH),
    .DW    (2 * PW)
  ) u_linebuf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_addr (x[AW-1:0]),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr),
    .wr_data ({lb_mid, s1_cur}),
    .rd_data (lb_rd)
  );

  assign lb_top = lb_rd[2*PW-1:PW];
  assign lb_mid = lb_rd[PW-1:0];

  // ---------------------------------------------------------------------
  // Window and clamp
  // ---------------------------------------------------------------------
  logic [CHANNELS-1:0][dnc_pkg::CHAN_W-1:0] clamped;

  dnc_window #(
    .CHANNELS (CHANNELS)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_adv),
    .top     (lb_top),
    .mid     (lb_mid),
    .cur     (s1_cur),
    .clamped (clamped)
  );

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [dnc_pkg::NUM_CHAN-1:0][dnc_pkg::CHAN_W-1:0] out_all;
  dnc_pkg::dnc_out_t                                 out_next;

  // Channels beyond the configured count read as zero.
  always_comb begin
    out_all = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      out_all[k] = clamped[k];
    end
    out_next.out_chan0  = out_all[0];
    out_next.out_chan1  = out_all[1];
    out_next.out_chan2  = out_all[2];
    out_next.out_chan3  = out_all[3];
    out_next.out_col    = s1_col;
    out_next.out_row    = s1_row;
    out_next.frame_done = s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_data <= out_next;
    end
  end

endmodule

// File: design/dnc_checker.sv
// Port-level checks for despeckle_neighbor_clamp_core, bound to the top.
// Depends on dnc_pkg and despeckle_neighbor_clamp_core_macros.svh.
`include "despeckle_neighbor_clamp_core_macros.svh"

module dnc_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input dnc_pkg::dnc_out_t out_data
);

  // Reset drops any pending result.
  `DNC_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !out_valid)

  // A result after an idle output comes from an accepted request.
  `DNC_ASSERT(a_result_has_request, clk, rst, $rose(out_valid) |-> $past(in_valid && !in_stall, 2))

  // Requests are held back only by a stalled result.
  `DNC_ASSERT(a_stall_cause, clk, rst, in_stall |-> out_valid && out_stall)

  // A stalled result holds.
  `DNC_ASSERT(a_result_holds, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data))

  // Centres never lie on the first row or column.
  `DNC_ASSERT(a_interior_only, clk, rst, out_valid |-> out_data.out_col != 0 && out_data.out_row != 0)

endmodule

bind despeckle_neighbor_clamp_core dnc_checker u_dnc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
